FILE: hdl/page_frame_fault_allocator_defines.svh
// assertion macros for the frame allocator checker
`ifndef PAGE_FRAME_FAULT_ALLOCATOR_DEFINES_SVH
`define PAGE_FRAME_FAULT_ALLOCATOR_DEFINES_SVH
// implication checked every clock outside reset
`define PFA_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// next-cycle implication checked outside reset
`define PFA_ASSERT_NXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

FILE: hdl/pffa_pkg.sv
// ----------------------------------------------------------------------------
// pffa_pkg
// shared types and codes of the frame allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package pffa_pkg;
  localparam logic CMD_TOUCH = 1'b0;
  localparam logic CMD_FAULT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FSRCH,
    ST_FWAIT,
    ST_ALLOC,
    ST_SCAN,
    ST_OWNRD,
    ST_OWNWT,
    ST_VSRCH,
    ST_VWAIT,
    ST_APPEND,
    ST_DONE
  } be_state_t;
endpackage

FILE: hdl/pffa_if.sv
// ----------------------------------------------------------------------------
// pffa_in_if / pffa_out_if
// valid/ready channels for input words and result words
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface pffa_in_if #(parameter int FRAMES = 64, parameter int PAGE_BITS = 10,
                       parameter int PROC_BITS = 4);
  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic [5:0]            touched_frame;
  logic [PROC_BITS-1:0]  proc_id;
  logic [PAGE_BITS-1:0]  virt_page;
  modport source (output valid, cmd, touched_frame, proc_id, virt_page, input ready);
  modport sink (input valid, cmd, touched_frame, proc_id, virt_page, output ready);
endinterface

interface pffa_out_if #(parameter int PAGE_BITS = 10, parameter int PROC_BITS = 4);
  logic                  valid;
  logic                  ready;
  logic [5:0]            frame_given;
  logic                  loaded_from_swap;
  logic                  evicted;
  logic [PROC_BITS-1:0]  victim_proc;
  logic [PAGE_BITS-1:0]  victim_page;
  logic                  victim_recorded;
  logic                  swap_overflow;
  modport source (output valid, frame_given, loaded_from_swap, evicted, victim_proc,
                  victim_page, victim_recorded, swap_overflow, input ready);
  modport sink (input valid, frame_given, loaded_from_swap, evicted, victim_proc,
                victim_page, victim_recorded, swap_overflow, output ready);
endinterface

FILE: hdl/pffa_ram.sv
// ----------------------------------------------------------------------------
// pffa_ram
// single-port-write, single-read RAM with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module pffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: hdl/pffa_front.sv
// ----------------------------------------------------------------------------
// pffa_front
// accepts words, passes touches on to the reference bits, queues faults
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module pffa_front import pffa_pkg::*; #(
  parameter int FRAMES    = 64,
  parameter int PAGE_BITS = 10,
  parameter int PROC_BITS = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  pffa_in_if.sink                      in_ch,
  output logic                         touch_en,
  output logic [5:0]                   touch_frame,
  output logic                         q_valid,
  input  logic                         q_pop,
  output logic [PROC_BITS+PAGE_BITS-1:0] q_data
);
  localparam int QW = PROC_BITS + PAGE_BITS;
  // two-entry fault queue
  logic [QW-1:0] qmem [2];
  logic          wp, rp;
  logic [1:0]    cnt;
  logic          push;

  // touches must not pass queued faults, so they wait for an empty queue
  assign in_ch.ready = (in_ch.cmd == CMD_FAULT) ? (cnt != 2'd2) : (cnt == 2'd0);
  assign push        = in_ch.valid && in_ch.ready && (in_ch.cmd == CMD_FAULT);
  assign touch_en    = in_ch.valid && in_ch.ready && (in_ch.cmd == CMD_TOUCH);
  assign touch_frame = in_ch.touched_frame;
  assign q_valid     = (cnt != 2'd0);
  assign q_data      = qmem[rp];

  always_ff @(posedge clk) begin
    if (push) qmem[wp] <= {in_ch.proc_id, in_ch.virt_page};
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

FILE: hdl/pffa_back.sv
// ----------------------------------------------------------------------------
// pffa_back
// carries out faults: swap search, frame pick, append, result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module pffa_back import pffa_pkg::*; #(
  parameter int FRAMES     = 64,
  parameter int SWAP_SLOTS = 1024,
  parameter int PAGE_BITS  = 10,
  parameter int PROC_BITS  = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           touch_en,
  input  logic [5:0]                     touch_frame,
  input  logic                           q_valid,
  output logic                           q_pop,
  input  logic [PROC_BITS+PAGE_BITS-1:0] q_data,
  pffa_out_if.source                     out_ch
);
  localparam int QW = PROC_BITS + PAGE_BITS;
  localparam int FB = $clog2(FRAMES);
  localparam int SB = $clog2(SWAP_SLOTS);

  be_state_t state, state_next;
  logic [FRAMES-1:0] ref_bits;
  logic [FB:0]       next_free;
  logic [SB:0]       swap_used;
  logic [SB:0]       idx;
  logic [FB-1:0]     fidx;
  logic [FB-1:0]     frame;
  logic [QW-1:0]     cur, victim;
  logic              found, hit, rec, ovf;

  // memories
  logic          own_we;
  logic [QW-1:0] own_rd;
  logic          sw_we;
  logic [SB-1:0] sw_raddr;
  logic [QW-1:0] sw_rd;

  pffa_ram #(.WIDTH(QW), .DEPTH(FRAMES)) u_own (
    .clk(clk), .we(own_we), .waddr(frame), .wdata(cur), .raddr(frame), .rdata(own_rd));
  pffa_ram #(.WIDTH(QW), .DEPTH(SWAP_SLOTS)) u_swap (
    .clk(clk), .we(sw_we), .waddr(swap_used[SB-1:0]), .wdata(victim),
    .raddr(sw_raddr), .rdata(sw_rd));

  assign sw_raddr = idx[SB-1:0];
  assign own_we   = (state == ST_DONE) && out_ch.ready;
  assign sw_we    = (state == ST_APPEND) && (swap_used < (SB+1)'(SWAP_SLOTS));
  assign q_pop    = own_we;
  assign out_ch.valid = (state == ST_DONE);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (q_valid) state_next = ST_FSRCH;
      ST_FSRCH:  state_next = (idx < swap_used) ? ST_FWAIT : ST_ALLOC;
      ST_FWAIT:  state_next = (sw_rd == cur) ? ST_ALLOC : ST_FSRCH;
      ST_ALLOC:  state_next = (next_free < (FB+1)'(FRAMES)) ? ST_DONE : ST_SCAN;
      ST_SCAN:   if (!ref_bits[fidx] || fidx == FB'(FRAMES-1)) state_next = ST_OWNRD;
      ST_OWNRD:  state_next = ST_OWNWT;
      ST_OWNWT:  state_next = found ? ST_VSRCH : ST_APPEND;
      ST_VSRCH:  state_next = (idx < swap_used) ? ST_VWAIT : ST_APPEND;
      ST_VWAIT:  state_next = (sw_rd == victim) ? ST_DONE : ST_VSRCH;
      ST_APPEND: state_next = ST_DONE;
      ST_DONE:   if (out_ch.ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_bits  <= '0;
      next_free <= '0;
      swap_used <= '0;
    end else begin
      if (touch_en && (32'(touch_frame) < FRAMES)) ref_bits[touch_frame[FB-1:0]] <= 1'b1;
      case (state)
        ST_ALLOC: if (next_free < (FB+1)'(FRAMES)) next_free <= next_free + 1'b1;
        ST_SCAN:  if (ref_bits[fidx]) ref_bits[fidx] <= 1'b0;
        ST_APPEND: if (sw_we) swap_used <= swap_used + 1'b1;
        ST_DONE:  if (out_ch.ready) ref_bits[frame] <= 1'b0;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cur <= q_data; idx <= '0; found <= 1'b0; hit <= 1'b0;
        rec <= 1'b0; ovf <= 1'b0; fidx <= '0;
      end
      ST_FSRCH: idx <= idx + 1'b1;
      ST_FWAIT: if (sw_rd == cur) found <= 1'b1;
      ST_ALLOC: begin
        idx <= '0;
        if (next_free < (FB+1)'(FRAMES)) frame <= next_free[FB-1:0];
      end
      ST_SCAN: begin
        // all bits set wraps to frame 0
        if (!ref_bits[fidx]) frame <= fidx;
        else if (fidx == FB'(FRAMES-1)) frame <= '0;
        fidx <= fidx + 1'b1;
        hit <= 1'b1;
      end
      ST_OWNWT: victim <= own_rd;
      ST_VSRCH: idx <= idx + 1'b1;
      ST_APPEND: begin
        rec <= sw_we;
        ovf <= !sw_we;
      end
      default: ;
    endcase
  end

  assign out_ch.frame_given      = 6'(frame);
  assign out_ch.loaded_from_swap = found;
  assign out_ch.evicted          = hit;
  assign out_ch.victim_proc      = hit ? victim[QW-1:PAGE_BITS] : '0;
  assign out_ch.victim_page      = hit ? victim[PAGE_BITS-1:0] : '0;
  assign out_ch.victim_recorded  = rec;
  assign out_ch.swap_overflow    = ovf;
endmodule

FILE: hdl/page_frame_fault_allocator.sv
// ----------------------------------------------------------------------------
// page_frame_fault_allocator
// second-chance frame allocator with a swap table
// ----------------------------------------------------------------------------
// touch: no result. fault: the swap table is searched serially through the
// single read port of the swap RAM.
// one fault is worked at a time; a two-word queue lets faults queue up.
// rst (synchronous) clears reference bits, free count and swap fill count.
`timescale 1ns / 1ps
module page_frame_fault_allocator import pffa_pkg::*; #(
  parameter int FRAMES     = 64,
  parameter int SWAP_SLOTS = 1024,
  parameter int PAGE_BITS  = 10,
  parameter int PROC_BITS  = 4
) (
  input logic         clk,
  input logic         rst,
  pffa_in_if.sink     in_ch,
  pffa_out_if.source  out_ch
);
  localparam int QW = PROC_BITS + PAGE_BITS;
  logic          touch_en;
  logic [5:0]    touch_frame;
  logic          q_valid, q_pop;
  logic [QW-1:0] q_data;

  pffa_front #(.FRAMES(FRAMES), .PAGE_BITS(PAGE_BITS), .PROC_BITS(PROC_BITS)) u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch), .touch_en(touch_en), .touch_frame(touch_frame),
    .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data));

  pffa_back #(.FRAMES(FRAMES), .SWAP_SLOTS(SWAP_SLOTS), .PAGE_BITS(PAGE_BITS),
              .PROC_BITS(PROC_BITS)) u_back (
    .clk(clk), .rst(rst), .touch_en(touch_en), .touch_frame(touch_frame),
    .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data), .out_ch(out_ch));
endmodule

FILE: hdl/pffa_checker.sv
// ----------------------------------------------------------------------------
// pffa_checker
// port-level checks of the frame allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "page_frame_fault_allocator_defines.svh"
module pffa_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic out_evicted,
  input logic out_recorded,
  input logic out_overflow,
  input logic [5:0] out_frame
);
  `PFA_ASSERT_IMP(a_rec_ovf, clk, rst, out_valid, !(out_recorded && out_overflow), "both")
  `PFA_ASSERT_IMP(a_rec_ev, clk, rst, out_valid && !out_evicted, !out_recorded && !out_overflow, "append without eviction")
  `PFA_ASSERT_NXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_frame), "result dropped")
endmodule

bind page_frame_fault_allocator pffa_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_evicted(out_ch.evicted), .out_recorded(out_ch.victim_recorded),
  .out_overflow(out_ch.swap_overflow), .out_frame(out_ch.frame_given));
